FILE: src/pad_origin_calibrator_macros.svh
// assertion helpers shared by the calibrator modules
// each expects clk and rst_n in scope
`ifndef PAD_ORIGIN_CALIBRATOR_MACROS_SVH
`define PAD_ORIGIN_CALIBRATOR_MACROS_SVH

// same-cycle implication
`define POC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define POC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/poc_pkg.sv
package poc_pkg;

  // one raw report
  typedef struct packed {
    logic        port_index;
    logic        link_active;
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [7:0]  port_status;
    logic [15:0] button_bytes;
    logic [7:0]  stick_x_raw;
    logic [7:0]  stick_y_raw;
    logic [7:0]  aux_stick_x_raw;
    logic [7:0]  aux_stick_y_raw;
    logic [7:0]  left_trigger_raw;
    logic [7:0]  right_trigger_raw;
  } poc_item_t;

  // one calibrated result
  typedef struct packed {
    logic [12:0]       button_word;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
    logic signed [7:0] aux_stick_x;
    logic signed [7:0] aux_stick_y;
    logic [7:0]        left_trigger;
    logic [7:0]        right_trigger;
    logic              error_code;
  } poc_result_t;

  // configuration register set
  typedef struct packed {
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [12:0] recal_mask;
  } poc_cfg_t;

  typedef enum logic [1:0] {
    CFG_VENDOR_ID  = 2'd0,
    CFG_PRODUCT_ID = 2'd1,
    CFG_RECAL_MASK = 2'd2
  } poc_cfg_idx_t;

  localparam int          CFG_INDEX_W   = 2;
  localparam int          CFG_DATA_W    = 16;
  localparam logic [15:0] RESET_VENDOR  = 16'h057E;
  localparam logic [15:0] RESET_PRODUCT = 16'h0337;
  localparam logic [12:0] RESET_RECAL   = 13'h1C00;
  localparam logic [7:0]  STATUS_WIRED    = 8'h10;
  localparam logic [7:0]  STATUS_WIRELESS = 8'h22;
  localparam logic signed [8:0] STICK_MIN = -9'sd128;
  localparam logic signed [8:0] STICK_MAX = 9'sd127;

  // low byte: ABXY low nibble, dpad high nibble; high byte: Start, Z R L
  function automatic logic [12:0] remap_buttons(input logic [15:0] b);
    logic [12:0] w;
    begin
      w        = '0;
      w[3:0]   = b[7:4];
      w[6:4]   = b[11:9];
      w[11:8]  = b[3:0];
      w[12]    = b[8];
      return w;
    end
  endfunction

  // raw minus origin, clamped to a signed byte
  function automatic logic signed [7:0] stick_offset(input logic [7:0] raw,
                                                     input logic [7:0] org);
    logic signed [8:0] d;
    begin
      d = $signed({1'b0, raw}) - $signed({1'b0, org});
      if (d < STICK_MIN)      return 8'sh80;
      else if (d > STICK_MAX) return 8'sh7F;
      else                    return d[7:0];
    end
  endfunction

  // raw minus origin, floored at zero
  function automatic logic [7:0] trigger_offset(input logic [7:0] raw,
                                                input logic [7:0] org);
    begin
      return (raw > org) ? raw - org : 8'd0;
    end
  endfunction

endpackage

FILE: src/pad_origin_calibrator.sv
// pad_origin_calibrator: per-port controller report calibration
// in_* stream: one raw report per transaction, port number in in_tuser; the
// report is checked for presence, its buttons remapped, and its six analog
// bytes offset against the origin captured for that port.
// out_* stream: one result per input transaction, in order; out_tuser is set
// when no controller is present, with out_tdata all zero.
// cfg_* port: register writes (vendor id, product id, recalibrate mask), taken
// on any cycle with cfg_we high, meant for idle periods only.
// An accepted transaction passes the input register, then the result register,
// before out_tvalid rises. Throughput: one transaction per cycle while
// out_tready is high; the per-port connected flag and origin are read and
// written in the same cycle as the result is formed, so back-to-back reports
// on one port see each other.
// Reset: clears both pipeline stages, all connected flags, and loads the
// default ids and mask; origins are captured on first connection.
// Stall: while out_tready is low the result is held, the input register fills
// and then in_tready drops, so no transaction is lost.
module pad_origin_calibrator #(
  parameter int PORT_COUNT = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // link_active, vendor_id, product_id, port_status, button_bytes, stick_x_raw,
  // stick_y_raw, aux_stick_x_raw, aux_stick_y_raw, left_trigger_raw,
  // right_trigger_raw
  input  logic [111:0]                     in_tdata,
  // port_index
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // button_word, stick_x, stick_y, aux_stick_x, aux_stick_y, left_trigger,
  // right_trigger
  output logic [63:0]                      out_tdata,
  // error_code
  output logic                             out_tuser,
  input  logic                             cfg_we,
  input  logic [poc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [poc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import poc_pkg::*;

  `include "pad_origin_calibrator_macros.svh"

  poc_item_t   in_item, s1_item;
  poc_result_t res, res_r;
  poc_cfg_t    cfg_r, cfg_nxt;
  logic        s1_valid, s1_take;
  logic        out_valid_r, out_valid_nxt;

  // unpack input transaction
  assign in_item.port_index        = in_tuser;
  assign in_item.link_active       = in_tdata[0];
  assign in_item.vendor_id         = in_tdata[16:1];
  assign in_item.product_id        = in_tdata[32:17];
  assign in_item.port_status       = in_tdata[40:33];
  assign in_item.button_bytes      = in_tdata[56:41];
  assign in_item.stick_x_raw       = in_tdata[64:57];
  assign in_item.stick_y_raw       = in_tdata[72:65];
  assign in_item.aux_stick_x_raw   = in_tdata[80:73];
  assign in_item.aux_stick_y_raw   = in_tdata[88:81];
  assign in_item.left_trigger_raw  = in_tdata[96:89];
  assign in_item.right_trigger_raw = in_tdata[104:97];

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (poc_cfg_idx_t'(cfg_index))
        CFG_VENDOR_ID:  cfg_nxt.vendor_id  = cfg_wdata;
        CFG_PRODUCT_ID: cfg_nxt.product_id = cfg_wdata;
        CFG_RECAL_MASK: cfg_nxt.recal_mask = cfg_wdata[12:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vendor_id  <= RESET_VENDOR;
      cfg_r.product_id <= RESET_PRODUCT;
      cfg_r.recal_mask <= RESET_RECAL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // result register frees up when empty or taken
  assign s1_take = s1_valid && (!out_valid_r || out_tready);

  poc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take)
  );

  poc_calib #(
    .PORT_COUNT (PORT_COUNT)
  ) u_calib (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_take),
    .item   (s1_item),
    .cfg    (cfg_r),
    .result (res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (!out_valid_r || out_tready) out_valid_nxt = s1_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (s1_take) res_r <= res;
  end

  // pack result transaction
  assign out_tvalid       = out_valid_r;
  assign out_tuser        = res_r.error_code;
  assign out_tdata[12:0]  = res_r.button_word;
  assign out_tdata[20:13] = res_r.stick_x;
  assign out_tdata[28:21] = res_r.stick_y;
  assign out_tdata[36:29] = res_r.aux_stick_x;
  assign out_tdata[44:37] = res_r.aux_stick_y;
  assign out_tdata[52:45] = res_r.left_trigger;
  assign out_tdata[60:53] = res_r.right_trigger;
  assign out_tdata[63:61] = 3'b000;

  `POC_ASSERT_IMP(a_err_clean, out_tvalid && out_tuser, out_tdata == '0, "error result with nonzero data")
  `POC_ASSERT_NXT(a_take_fills, s1_take, out_tvalid, "taken item did not reach result register")
  `POC_ASSERT_IMP(a_ready_free, !s1_valid, in_tready, "input stage empty but not ready")

endmodule

FILE: src/poc_in_stage.sv
module poc_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  poc_pkg::poc_item_t in_item,
  output logic               s1_valid,
  output poc_pkg::poc_item_t s1_item,
  input  logic               s1_take
);
  import poc_pkg::*;

  logic      valid_r, valid_nxt;
  poc_item_t item_r;

  // stage is free when empty or being drained this cycle
  assign in_ready = !valid_r || s1_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) valid_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  // payload register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) item_r <= in_item;
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

FILE: src/poc_calib.sv
module poc_calib #(
  parameter int PORT_COUNT = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  poc_pkg::poc_item_t   item,
  input  poc_pkg::poc_cfg_t    cfg,
  output poc_pkg::poc_result_t result
);
  import poc_pkg::*;

  `include "pad_origin_calibrator_macros.svh"

  localparam int PIDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

  logic [PORT_COUNT-1:0]   conn_r, conn_nxt;
  logic [5:0][7:0]         origin_r [PORT_COUNT];
  logic [5:0][7:0]         raw, org_stored, org_eff;
  logic [PIDX_W-1:0]       idx;
  logic                    port_ok, status_ok, present, recapture;
  logic [12:0]             word;

  assign raw = {item.right_trigger_raw, item.left_trigger_raw, item.aux_stick_y_raw,
                item.aux_stick_x_raw, item.stick_y_raw, item.stick_x_raw};

  // port decode and presence
  assign port_ok   = (32'(item.port_index) < PORT_COUNT);
  assign idx       = port_ok ? PIDX_W'(item.port_index) : '0;
  assign status_ok = ((item.port_status & STATUS_WIRED) == STATUS_WIRED) ||
                     ((item.port_status & STATUS_WIRELESS) == STATUS_WIRELESS);
  assign present   = port_ok && item.link_active && status_ok &&
                     (item.vendor_id == cfg.vendor_id) &&
                     (item.product_id == cfg.product_id);

  assign word       = remap_buttons(item.button_bytes);
  assign recapture  = !conn_r[idx] || ((word & cfg.recal_mask) == cfg.recal_mask);
  assign org_stored = origin_r[idx];
  assign org_eff    = recapture ? raw : org_stored;

  // result
  always_comb begin
    result = '0;
    if (!present) begin
      result.error_code = 1'b1;
    end else begin
      result.button_word   = word;
      result.stick_x       = stick_offset(raw[0], org_eff[0]);
      result.stick_y       = stick_offset(raw[1], org_eff[1]);
      result.aux_stick_x   = stick_offset(raw[2], org_eff[2]);
      result.aux_stick_y   = stick_offset(raw[3], org_eff[3]);
      result.left_trigger  = trigger_offset(raw[4], org_eff[4]);
      result.right_trigger = trigger_offset(raw[5], org_eff[5]);
    end
  end

  // connected flags
  always_comb begin
    conn_nxt = conn_r;
    if (fire && port_ok) conn_nxt[idx] = present;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) conn_r <= '0;
    else        conn_r <= conn_nxt;
  end

  // origin capture
  always_ff @(posedge clk) begin
    if (fire && present && recapture) origin_r[idx] <= raw;
  end

  `POC_ASSERT_NXT(a_conn_set, fire && present, conn_r[$past(idx)], "present port not marked connected")
  `POC_ASSERT_NXT(a_conn_clr, fire && port_ok && !present, !conn_r[$past(idx)], "absent port still connected")
  `POC_ASSERT_IMP(a_err_zero, result.error_code, result.button_word == '0 && result.left_trigger == '0, "error result carries data")

endmodule
